>>> design/arp_cache_update_and_reply_defines.svh
// Assertion macros for the checker
`ifndef ARP_CACHE_UPDATE_AND_REPLY_DEFINES_SVH
`define ARP_CACHE_UPDATE_AND_REPLY_DEFINES_SVH

// clocked check, disabled while reset is asserted
`define ARPC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define ARPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/arpc_pkg.sv
package arpc_pkg;

    localparam int OPC_W = 16;
    localparam int IP_W  = 32;
    localparam int MAC_W = 48;
    localparam int ACT_W = 3;

    localparam logic [OPC_W-1:0] OPCODE_REQUEST = 16'd1;
    localparam logic [OPC_W-1:0] OPCODE_REPLY   = 16'd2;

    typedef enum logic [ACT_W-1:0] {
        ACT_SAME     = 3'd0,
        ACT_UPDATED  = 3'd1,
        ACT_INSERTED = 3'd2,
        ACT_FULL     = 3'd3,
        ACT_IGNORED  = 3'd4
    } t_action;

    // lookup token walking down the cell chain
    typedef struct packed {
        logic             live;
        logic             done;
        t_action          action;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } t_probe;

endpackage

>>> design/arpc_if.sv
interface arpc_in_if;
    logic                        valid;
    logic                        ready;
    logic [arpc_pkg::OPC_W-1:0]  arp_opcode;
    logic [arpc_pkg::IP_W-1:0]   src_ip;
    logic [arpc_pkg::MAC_W-1:0]  src_mac;
    logic                        tx_buffer_free;

    modport source (output valid, arp_opcode, src_ip, src_mac, tx_buffer_free,
                    input ready);
    modport sink   (input valid, arp_opcode, src_ip, src_mac, tx_buffer_free,
                    output ready);
endinterface

interface arpc_out_if;
    logic                        valid;
    logic                        ready;
    logic                        send_reply;
    logic [arpc_pkg::MAC_W-1:0]  reply_target_mac;
    logic [arpc_pkg::IP_W-1:0]   reply_target_ip;
    logic [arpc_pkg::ACT_W-1:0]  table_action;

    modport source (output valid, send_reply, reply_target_mac, reply_target_ip,
                    table_action, input ready);
    modport sink   (input valid, send_reply, reply_target_mac, reply_target_ip,
                    table_action, output ready);
endinterface

>>> design/arpc_cell.sv
module arpc_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  arpc_pkg::t_probe i_probe,
    output arpc_pkg::t_probe o_probe
);

    logic                       r_valid;
    logic [arpc_pkg::IP_W-1:0]  r_ip;
    logic [arpc_pkg::MAC_W-1:0] r_mac;
    arpc_pkg::t_probe           r_probe;
    arpc_pkg::t_probe           n_probe;
    logic                       w_search;
    logic                       w_hit;
    logic                       w_take;

    assign w_search = i_probe.live && !i_probe.done;
    assign w_hit    = w_search && r_valid && (r_ip == i_probe.ip);
    assign w_take   = w_search && !r_valid;

    always_comb begin
        n_probe = i_probe;
        if (w_hit) begin
            n_probe.done   = 1'b1;
            n_probe.action = (r_mac == i_probe.mac) ? arpc_pkg::ACT_SAME
                                                    : arpc_pkg::ACT_UPDATED;
        end else if (w_take) begin
            n_probe.done   = 1'b1;
            n_probe.action = arpc_pkg::ACT_INSERTED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_probe.live <= 1'b0;
        end else begin
            r_probe <= n_probe;
            if (w_take) begin
                r_valid <= 1'b1;
            end
        end
        if (w_take) begin
            r_ip <= i_probe.ip;
        end
        if (w_hit || w_take) begin
            r_mac <= i_probe.mac;
        end
    end

    assign o_probe = r_probe;

endmodule

>>> design/arp_cache_update_and_reply.sv
// Each accepted request is registered into a lookup token that steps one cell of the entry
// chain per cycle, then waits in a pending register before loading into the output register.
// One request at a time: the input is not ready until its result moves to the output.
// A new request is taken while the previous result still waits at the output.
// Reset (synchronous, active low) empties the table and drops any request in flight.
module arp_cache_update_and_reply #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    arpc_in_if.sink     i_req,
    arpc_out_if.source  o_rsp
);

    arpc_pkg::t_probe           w_chain [0:TABLE_ENTRIES];
    arpc_pkg::t_probe           r_inj;
    logic                       r_busy;
    logic                       r_send;
    logic [arpc_pkg::IP_W-1:0]  r_ip;
    logic [arpc_pkg::MAC_W-1:0] r_mac;
    logic                       r_pend_valid;
    arpc_pkg::t_action          r_pend_action;
    logic                       r_out_valid;
    logic                       r_out_send;
    logic [arpc_pkg::IP_W-1:0]  r_out_ip;
    logic [arpc_pkg::MAC_W-1:0] r_out_mac;
    arpc_pkg::t_action          r_out_action;

    logic                       w_in_valid;
    logic                       w_in_ready;
    logic                       w_out_valid;
    logic                       w_out_ready;
    logic                       w_accept;
    logic                       w_learn;
    logic                       w_load;

    assign w_in_valid  = i_req.valid;
    assign w_in_ready  = !r_busy;
    assign w_out_valid = r_out_valid;
    assign w_out_ready = o_rsp.ready;
    assign w_accept    = w_in_valid && w_in_ready;
    assign w_learn     = (i_req.arp_opcode == arpc_pkg::OPCODE_REQUEST) ||
                         (i_req.arp_opcode == arpc_pkg::OPCODE_REPLY);
    assign w_load      = r_pend_valid && (!r_out_valid || w_out_ready);

    assign w_chain[0] = r_inj;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        arpc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_probe (w_chain[g]),
            .o_probe (w_chain[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_inj.live   <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_inj.live <= w_accept;
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_load) begin
                r_busy <= 1'b0;
            end
            if (w_chain[TABLE_ENTRIES].live) begin
                r_pend_valid <= 1'b1;
            end else if (w_load) begin
                r_pend_valid <= 1'b0;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (w_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_inj.done   <= !w_learn;
            r_inj.action <= w_learn ? arpc_pkg::ACT_SAME : arpc_pkg::ACT_IGNORED;
            r_inj.ip     <= i_req.src_ip;
            r_inj.mac    <= i_req.src_mac;
            r_send       <= (i_req.arp_opcode == arpc_pkg::OPCODE_REQUEST) &&
                            i_req.tx_buffer_free;
            r_ip         <= i_req.src_ip;
            r_mac        <= i_req.src_mac;
        end
        if (w_chain[TABLE_ENTRIES].live) begin
            r_pend_action <= w_chain[TABLE_ENTRIES].done ? w_chain[TABLE_ENTRIES].action
                                                         : arpc_pkg::ACT_FULL;
        end
        if (w_load) begin
            r_out_send   <= r_send;
            r_out_ip     <= r_send ? r_ip : '0;
            r_out_mac    <= r_send ? r_mac : '0;
            r_out_action <= r_pend_action;
        end
    end

    assign i_req.ready            = w_in_ready;
    assign o_rsp.valid            = w_out_valid;
    assign o_rsp.send_reply       = r_out_send;
    assign o_rsp.reply_target_ip  = r_out_ip;
    assign o_rsp.reply_target_mac = r_out_mac;
    assign o_rsp.table_action     = r_out_action;

endmodule

>>> design/arpc_checker.sv
`include "arp_cache_update_and_reply_defines.svh"

module arpc_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic                       i_send_reply,
    input logic [arpc_pkg::IP_W-1:0]  i_reply_ip,
    input logic [arpc_pkg::MAC_W-1:0] i_reply_mac,
    input logic [arpc_pkg::ACT_W-1:0] i_action
);

    `ARPC_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "result dropped while stalled")
    `ARPC_ASSERT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && i_in_ready |=> !i_in_ready, "second request taken during lookup")
    `ARPC_ASSERT(a_reply_fields, i_clk, i_rst_n, i_out_valid && !i_send_reply |-> i_reply_ip == '0 && i_reply_mac == '0, "reply address set without reply")
    `ARPC_ASSERT(a_reply_action, i_clk, i_rst_n, i_out_valid && i_send_reply |-> i_action != arpc_pkg::ACT_IGNORED && i_action <= arpc_pkg::ACT_FULL, "reply with bad table action")

endmodule

bind arp_cache_update_and_reply arpc_checker u_arpc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (w_in_valid),
    .i_in_ready  (w_in_ready),
    .i_out_valid (w_out_valid),
    .i_out_ready (w_out_ready),
    .i_send_reply(r_out_send),
    .i_reply_ip  (r_out_ip),
    .i_reply_mac (r_out_mac),
    .i_action    (r_out_action)
);
